### src/unsigned_decimal_formatter_assert.svh
// assertion macros for the unsigned decimal formatter checker
// needs clk_i and rst_ni in the scope where the macros are used
`ifndef UNSIGNED_DECIMAL_FORMATTER_ASSERT_SVH
`define UNSIGNED_DECIMAL_FORMATTER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define UDF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define UDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/udf_pkg.sv
// shared constants for the unsigned decimal formatter
// no dependencies
`timescale 1ns / 1ps

package udf_pkg;

  // input value and bcd conversion sizes
  localparam int unsigned VALUE_W       = 64;
  localparam int unsigned BCD_DIGITS    = 20;
  localparam int unsigned BCD_W         = 4 * BCD_DIGITS;
  localparam int unsigned BITS_PER_STEP = 2;
  localparam int unsigned CONV_STEPS    = VALUE_W / BITS_PER_STEP;
  localparam int unsigned CONV_CNT_W    = $clog2(CONV_STEPS);
  localparam int unsigned DIG_IDX_W     = $clog2(BCD_DIGITS);
  localparam int unsigned NDIG_W        = $clog2(BCD_DIGITS + 1);

  // configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CFG_NUM_W  = 6;

  localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIGITS   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_JUSTIFY = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_PAD     = 4'd3;

  localparam logic [CFG_NUM_W-1:0] FIELD_WIDTH_RST = 6'd0;
  localparam logic [CFG_NUM_W-1:0] MIN_DIGITS_RST  = 6'd1;

  // ascii codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

endpackage

### src/unsigned_decimal_formatter.sv
// Unsigned decimal formatter: writes one 64-bit value as printf-style
// decimal text, one ASCII character per output transaction.
// Channels: input (in_valid_i / in_stall_o / value_i), output
// (out_valid_o / out_stall_i / out_char_o / last_o), and a configuration
// write port (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i) for
// field_width (0), min_digits (1), left_justify (2) and zero_pad (3).
// A value is taken when in_valid_i is high and in_stall_o low; the block
// then holds in_stall_o high until its whole field has been loaded into
// the output register.
// Steps: binary to bcd conversion in ST_CONV (shared shift-add-3 unit,
// two bits a cycle), a digit count in ST_COUNT, the field plan in ST_PLAN,
// then in ST_EMIT one character per cycle while the receiver does not
// stall. The field length is at most MAX_FIELD.
// A zero value with min_digits 0 and field_width 0 gives no characters.
// A stalled receiver holds the character in the output register; nothing is lost.
// Reset clears the sequencer and output valid and loads the register
// defaults (width 0, min_digits 1, no flags). Configuration writes are
// always accepted and should only happen while the block is idle.
// Depends on udf_pkg.
`timescale 1ns / 1ps

module unsigned_decimal_formatter #(
  parameter int unsigned MAX_FIELD = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [udf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [udf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input values
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [udf_pkg::VALUE_W-1:0]      value_i,
  // output characters
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [7:0]                       out_char_o,
  output logic                             last_o
);

  localparam int unsigned CNT_W = $clog2(MAX_FIELD + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_COUNT,
    ST_PLAN,
    ST_EMIT
  } state_e;

  // control and output registers
  state_e                            state_q, state_d;
  logic                              out_valid_q, out_valid_d;
  logic [7:0]                        out_char_q, out_char_d;
  logic                              out_last_q, out_last_d;
  logic [udf_pkg::CFG_NUM_W-1:0]     field_width_q;
  logic [udf_pkg::CFG_NUM_W-1:0]     min_digits_q;
  logic                              left_justify_q;
  logic                              zero_pad_q;

  // datapath registers
  logic [udf_pkg::VALUE_W-1:0]       bin_q, bin_d;
  logic [udf_pkg::BCD_W-1:0]         bcd_q, bcd_d;
  logic [udf_pkg::CONV_CNT_W-1:0]    conv_cnt_q, conv_cnt_d;
  logic [udf_pkg::NDIG_W-1:0]        ndig_q, ndig_d;
  logic [CNT_W-1:0]                  pos_q, pos_d;
  logic [CNT_W-1:0]                  total_q, total_d;
  logic [CNT_W-1:0]                  zero_start_q, zero_start_d;
  logic [CNT_W-1:0]                  zero_end_q, zero_end_d;
  logic [CNT_W-1:0]                  dig_end_q, dig_end_d;
  logic [7:0]                        pad_char_q, pad_char_d;

  // add 3 to every bcd digit of five or more
  function automatic logic [udf_pkg::BCD_W-1:0] bcd_adjust(
    input logic [udf_pkg::BCD_W-1:0] bcd
  );
    logic [udf_pkg::BCD_W-1:0] res;
    res = bcd;
    for (int i = 0; i < int'(udf_pkg::BCD_DIGITS); i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

  // shared conversion unit: two shift-add-3 steps
  logic [udf_pkg::BCD_W-1:0] bcd_adj1, bcd_adj2;
  logic [udf_pkg::BCD_W-1:0] bcd_step1, bcd_step2;
  always_comb begin
    bcd_adj1  = bcd_adjust(bcd_q);
    bcd_step1 = {bcd_adj1[udf_pkg::BCD_W-2:0], bin_q[udf_pkg::VALUE_W-1]};
    bcd_adj2  = bcd_adjust(bcd_step1);
    bcd_step2 = {bcd_adj2[udf_pkg::BCD_W-2:0], bin_q[udf_pkg::VALUE_W-2]};
  end

  // significant digit count from the bcd result
  logic [udf_pkg::NDIG_W-1:0] ndig_calc;
  always_comb begin
    ndig_calc = '0;
    for (int i = 0; i < int'(udf_pkg::BCD_DIGITS); i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) begin
        ndig_calc = udf_pkg::NDIG_W'(i + 1);
      end
    end
  end

  // clamped register values and field plan
  logic [CNT_W-1:0] width_c, prec_c, ndig_c, zeros_c, body_c, pads_c, total_c;
  always_comb begin
    width_c = (int'(field_width_q) > int'(MAX_FIELD)) ? CNT_W'(MAX_FIELD)
                                                       : CNT_W'(field_width_q);
    prec_c  = (int'(min_digits_q) > int'(MAX_FIELD)) ? CNT_W'(MAX_FIELD)
                                                      : CNT_W'(min_digits_q);
    ndig_c  = CNT_W'(ndig_q);
    zeros_c = (prec_c > ndig_c) ? prec_c - ndig_c : '0;
    body_c  = ndig_c + zeros_c;
    pads_c  = (body_c < width_c) ? width_c - body_c : '0;
    total_c = body_c + pads_c;
  end

  // character at the current position
  logic [CNT_W-1:0]               dig_off;
  logic [udf_pkg::DIG_IDX_W-1:0]  dig_idx;
  logic [3:0]                     dig_val;
  logic [7:0]                     cur_char;
  always_comb begin
    dig_off = dig_end_q - pos_q - CNT_W'(1);
    dig_idx = dig_off[udf_pkg::DIG_IDX_W-1:0];
    dig_val = bcd_q[{dig_idx, 2'b00} +: 4];
    if (pos_q < zero_start_q) begin
      cur_char = pad_char_q;
    end else if (pos_q < zero_end_q) begin
      cur_char = udf_pkg::CHAR_ZERO;
    end else if (pos_q < dig_end_q) begin
      cur_char = udf_pkg::CHAR_ZERO | {4'd0, dig_val};
    end else begin
      cur_char = pad_char_q;
    end
  end

  // sequencer
  logic out_free;
  logic is_last;
  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q & out_stall_i;
    out_char_d   = out_char_q;
    out_last_d   = out_last_q;
    bin_d        = bin_q;
    bcd_d        = bcd_q;
    conv_cnt_d   = conv_cnt_q;
    ndig_d       = ndig_q;
    pos_d        = pos_q;
    total_d      = total_q;
    zero_start_d = zero_start_q;
    zero_end_d   = zero_end_q;
    dig_end_d    = dig_end_q;
    pad_char_d   = pad_char_q;
    out_free     = ~out_valid_q | ~out_stall_i;
    is_last      = (pos_q == total_q - CNT_W'(1));

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          bin_d      = value_i;
          bcd_d      = '0;
          conv_cnt_d = '0;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_d      = bcd_step2;
        bin_d      = {bin_q[udf_pkg::VALUE_W-3:0], 2'b00};
        conv_cnt_d = conv_cnt_q + udf_pkg::CONV_CNT_W'(1);
        if (conv_cnt_q == udf_pkg::CONV_CNT_W'(udf_pkg::CONV_STEPS - 1)) begin
          state_d = ST_COUNT;
        end
      end
      ST_COUNT: begin
        ndig_d  = ndig_calc;
        state_d = ST_PLAN;
      end
      ST_PLAN: begin
        total_d = total_c;
        pos_d   = '0;
        if (left_justify_q) begin
          zero_start_d = '0;
          zero_end_d   = zeros_c;
          dig_end_d    = body_c;
          pad_char_d   = udf_pkg::CHAR_SPACE;
        end else begin
          zero_start_d = pads_c;
          zero_end_d   = pads_c + zeros_c;
          dig_end_d    = total_c;
          pad_char_d   = zero_pad_q ? udf_pkg::CHAR_ZERO : udf_pkg::CHAR_SPACE;
        end
        state_d = (total_c == '0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = cur_char;
          out_last_d  = is_last;
          pos_d       = pos_q + CNT_W'(1);
          if (is_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state, output register and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      out_valid_q    <= 1'b0;
      out_char_q     <= '0;
      out_last_q     <= 1'b0;
      field_width_q  <= udf_pkg::FIELD_WIDTH_RST;
      min_digits_q   <= udf_pkg::MIN_DIGITS_RST;
      left_justify_q <= 1'b0;
      zero_pad_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      out_char_q  <= out_char_d;
      out_last_q  <= out_last_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          udf_pkg::REG_FIELD_WIDTH:  field_width_q  <= cfg_data_i[udf_pkg::CFG_NUM_W-1:0];
          udf_pkg::REG_MIN_DIGITS:   min_digits_q   <= cfg_data_i[udf_pkg::CFG_NUM_W-1:0];
          udf_pkg::REG_LEFT_JUSTIFY: left_justify_q <= cfg_data_i[0];
          udf_pkg::REG_ZERO_PAD:     zero_pad_q     <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    bin_q        <= bin_d;
    bcd_q        <= bcd_d;
    conv_cnt_q   <= conv_cnt_d;
    ndig_q       <= ndig_d;
    pos_q        <= pos_d;
    total_q      <= total_d;
    zero_start_q <= zero_start_d;
    zero_end_q   <= zero_end_d;
    dig_end_q    <= dig_end_d;
    pad_char_q   <= pad_char_d;
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = out_last_q;

endmodule

### src/udf_checker.sv
// port-level checker for the unsigned decimal formatter, bound to the top level
// depends on udf_pkg and unsigned_decimal_formatter_assert.svh
`timescale 1ns / 1ps
`include "unsigned_decimal_formatter_assert.svh"

module udf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [7:0]                      out_char_o,
  input logic                            last_o
);

  // conversion is sequential, so an accepted value blocks the input
  `UDF_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "input not blocked after transaction")

  // only digits, spaces appear in the text
  `UDF_ASSERT_NOW(a_char_set, out_valid_o, (out_char_o == udf_pkg::CHAR_SPACE) || ((out_char_o >= udf_pkg::CHAR_ZERO) && (out_char_o <= udf_pkg::CHAR_NINE)), "character outside digit and space set")

  // a field still being written keeps the input blocked
  `UDF_ASSERT_NOW(a_busy_mid_field, out_valid_o && !last_o, in_stall_o, "input open in the middle of a field")

  // stalled output transaction holds
  `UDF_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_char_o) && $stable(last_o), "stalled output changed")

endmodule

bind unsigned_decimal_formatter udf_checker u_udf_checker (.*);
